@@ hdl/swc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swc_pkg;

   localparam int TIME_WIDTH_DEFAULT       = 64;
   localparam int GENERATION_WIDTH_DEFAULT = 32;

   // register indexes
   localparam logic [1:0] CSR_HOLD_TIME       = 2'd0;
   localparam logic [1:0] CSR_WINDOW_DURATION = 2'd1;
   localparam logic [1:0] CSR_START_TIMEOUT   = 2'd2;
   localparam logic [1:0] CSR_ATTEMPT_LIMIT   = 2'd3;

   localparam logic [31:0] HOLD_TIME_RESET       = 32'd3000;
   localparam logic [31:0] WINDOW_DURATION_RESET = 32'd900000;
   localparam logic [31:0] START_TIMEOUT_RESET   = 32'd10000;
   localparam logic [7:0]  ATTEMPT_LIMIT_RESET   = 8'd1;

   localparam logic [7:0] ATTEMPT_MAX = 8'd255;

   // mode codes as seen on the result
   localparam logic [2:0] MODE_OFF      = 3'd0;
   localparam logic [2:0] MODE_STARTING = 3'd1;
   localparam logic [2:0] MODE_ACTIVE   = 3'd2;
   localparam logic [2:0] MODE_STOPPING = 3'd3;
   localparam logic [2:0] MODE_FAULT    = 3'd4;

   localparam logic [1:0] FAULT_NONE         = 2'd0;
   localparam logic [1:0] FAULT_START_FAILED = 2'd1;
   localparam logic [1:0] FAULT_UNEXP_STOP   = 2'd2;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_STARTED = 2'd1,
      EV_STOPPED = 2'd2,
      EV_FAILED  = 2'd3
   } radio_event_type;

   typedef struct packed {
      logic [63:0] time_now;
      logic        button_level;
      logic [1:0]  radio_event;
      logic        close_request;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode_state;
      logic        is_active;
      logic [31:0] time_left;
      logic [7:0]  attempts_made;
      logic [31:0] generation;
      logic [1:0]  fault_code;
      logic        start_radio;
      logic        stop_radio;
      logic        drop_sessions;
   } rsp_type;

   typedef struct packed {
      logic [31:0] hold_time;
      logic [31:0] window_duration;
      logic [31:0] start_timeout;
      logic [7:0]  attempt_limit;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/swc_button.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swc_button import swc_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  pressed,
   input  wire logic [TIME_WIDTH-1:0] now,
   input  wire logic [31:0]           hold_time,
   output logic                       fire
);

   logic                  tracking_ff, tracking_in;
   logic                  latched_ff, latched_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;
   logic [TIME_WIDTH-1:0] start_eff;
   logic [TIME_WIDTH-1:0] held;

   assign start_eff = tracking_ff ? start_ff : now;
   assign held      = now - start_eff;

   always_comb begin
      tracking_in = tracking_ff;
      latched_in  = latched_ff;
      start_in    = start_ff;
      fire        = 1'b0;
      if (!pressed) begin
         tracking_in = 1'b0;
         latched_in  = 1'b0;
         start_in    = '0;
      end else begin
         tracking_in = 1'b1;
         start_in    = start_eff;
         if (now < start_eff) begin
            start_in = now;
         end else if (!latched_ff && held >= TIME_WIDTH'(hold_time)) begin
            latched_in = 1'b1;
            fire       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff <= 1'b0;
         latched_ff  <= 1'b0;
         start_ff    <= '0;
      end else if (step) begin
         tracking_ff <= tracking_in;
         latched_ff  <= latched_in;
         start_ff    <= start_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/swc_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swc_fsm import swc_pkg::*; #(
   parameter int TIME_WIDTH       = TIME_WIDTH_DEFAULT,
   parameter int GENERATION_WIDTH = GENERATION_WIDTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [TIME_WIDTH-1:0] now,
   input  wire logic                  fire,
   input  wire logic [1:0]            radio_event,
   input  wire logic                  close_request,
   input  wire cfg_type               cfg,
   output rsp_type                    result
);

   typedef enum logic [2:0] {
      ST_OFF      = MODE_OFF,
      ST_STARTING = MODE_STARTING,
      ST_ACTIVE   = MODE_ACTIVE,
      ST_STOPPING = MODE_STOPPING,
      ST_FAULT    = MODE_FAULT
   } mode_state_type;

   mode_state_type              mode_ff, mode_in, mode_mid;
   logic [1:0]                  fault_ff, fault_in;
   logic [7:0]                  attempt_ff, attempt_in, attempt_mid;
   logic [GENERATION_WIDTH-1:0] gen_ff, gen_in;
   logic [TIME_WIDTH-1:0]       deadline_ff, deadline_in, deadline_mid;
   logic [TIME_WIDTH-1:0]       expiry_ff, expiry_in;
   logic [TIME_WIDTH:0]         sum_timeout, sum_window;
   logic [TIME_WIDTH-1:0]       start_dl, window_end, left;
   logic                        act_start, act_stop, act_drop;
   radio_event_type             ev;

   assign ev = radio_event_type'(radio_event);

   // saturating deadlines
   assign sum_timeout = {1'b0, now} + (TIME_WIDTH + 1)'(cfg.start_timeout);
   assign sum_window  = {1'b0, now} + (TIME_WIDTH + 1)'(cfg.window_duration);
   assign start_dl    = sum_timeout[TIME_WIDTH] ? '1 : sum_timeout[TIME_WIDTH-1:0];
   assign window_end  = sum_window[TIME_WIDTH] ? '1 : sum_window[TIME_WIDTH-1:0];

   function automatic logic [7:0] bump(input logic [7:0] cnt);
      bump = (cnt < ATTEMPT_MAX) ? cnt + 8'd1 : cnt;
   endfunction

   always_comb begin
      mode_in     = mode_ff;
      fault_in    = fault_ff;
      attempt_in  = attempt_ff;
      gen_in      = gen_ff;
      deadline_in = deadline_ff;
      expiry_in   = expiry_ff;
      act_start   = 1'b0;
      act_stop    = 1'b0;
      act_drop    = 1'b0;

      // button start from off or fault
      mode_mid     = mode_ff;
      attempt_mid  = attempt_ff;
      deadline_mid = deadline_ff;
      if (fire && (mode_ff == ST_OFF || mode_ff == ST_FAULT)) begin
         fault_in     = FAULT_NONE;
         mode_mid     = ST_STARTING;
         attempt_mid  = 8'd1;
         deadline_mid = start_dl;
         act_start    = 1'b1;
      end
      mode_in     = mode_mid;
      attempt_in  = attempt_mid;
      deadline_in = deadline_mid;

      unique case (mode_mid)
         ST_STARTING: begin
            if (ev == EV_STARTED) begin
               mode_in     = ST_ACTIVE;
               deadline_in = '0;
               expiry_in   = window_end;
            end else if (ev == EV_FAILED || now >= deadline_mid) begin
               if (attempt_mid < cfg.attempt_limit) begin
                  attempt_in  = bump(attempt_mid);
                  deadline_in = start_dl;
                  act_start   = 1'b1;
               end else begin
                  mode_in     = ST_FAULT;
                  deadline_in = '0;
                  fault_in    = FAULT_START_FAILED;
                  gen_in      = gen_ff + GENERATION_WIDTH'(1);
                  act_drop    = 1'b1;
               end
            end
         end
         ST_ACTIVE: begin
            if (ev == EV_STOPPED) begin
               // unexpected stop: drop sessions and restart the radio
               fault_in    = FAULT_UNEXP_STOP;
               expiry_in   = '0;
               gen_in      = gen_ff + GENERATION_WIDTH'(1);
               act_drop    = 1'b1;
               mode_in     = ST_STARTING;
               attempt_in  = 8'd1;
               deadline_in = start_dl;
               act_start   = 1'b1;
            end else if (close_request || now >= expiry_ff) begin
               mode_in   = ST_STOPPING;
               expiry_in = '0;
               act_stop  = 1'b1;
            end
         end
         ST_STOPPING: begin
            if (ev == EV_STOPPED) begin
               mode_in    = ST_OFF;
               attempt_in = '0;
               gen_in     = gen_ff + GENERATION_WIDTH'(1);
               act_drop   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign left = expiry_in - now;

   always_comb begin
      result.mode_state    = mode_in;
      result.is_active     = (mode_in == ST_ACTIVE);
      result.time_left     = '0;
      if (mode_in == ST_ACTIVE && now < expiry_in) begin
         result.time_left = (left > TIME_WIDTH'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : left[31:0];
      end
      result.attempts_made = attempt_in;
      result.generation    = 32'(gen_in);
      result.fault_code    = fault_in;
      result.start_radio   = act_start;
      result.stop_radio    = act_stop;
      result.drop_sessions = act_drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ST_OFF;
         fault_ff    <= FAULT_NONE;
         attempt_ff  <= '0;
         gen_ff      <= '0;
         deadline_ff <= '0;
         expiry_ff   <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         fault_ff    <= fault_in;
         attempt_ff  <= attempt_in;
         gen_ff      <= gen_in;
         deadline_ff <= deadline_in;
         expiry_ff   <= expiry_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/service_window_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_data  (req_type)
// rsp      out        rsp_valid / rsp_ready    rsp_data  (rsp_type)
// csr      in         csr_write_en             csr_index, csr_wdata
//
// One beat per cycle sustained while rsp_ready stays high; a taken request beat
// sits in the input register, then one pass of the mode logic fills the result
// register. Synchronous reset clears the valid flags, the time clamp, the press
// tracker and all mode state, and loads the register defaults. A stalled result
// holds in the result register while the input register takes one more beat.

module service_window_controller import swc_pkg::*; #(
   parameter int TIME_WIDTH       = TIME_WIDTH_DEFAULT,
   parameter int GENERATION_WIDTH = GENERATION_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   req_type               in_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff;
   cfg_type               cfg_ff, cfg_in;
   logic [TIME_WIDTH-1:0] last_time_ff;
   logic [TIME_WIDTH-1:0] now_raw, now;
   logic                  advance, step, fire;
   rsp_type               result;

   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign out_valid_in = step ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // time never runs backward
   assign now_raw = in_ff.time_now[TIME_WIDTH-1:0];
   assign now     = (now_raw < last_time_ff) ? last_time_ff : now_raw;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HOLD_TIME:
               cfg_in.hold_time = (csr_wdata == '0) ? HOLD_TIME_RESET : csr_wdata;
            CSR_WINDOW_DURATION:
               cfg_in.window_duration = (csr_wdata == '0) ? WINDOW_DURATION_RESET : csr_wdata;
            CSR_START_TIMEOUT:
               cfg_in.start_timeout = (csr_wdata == '0) ? START_TIMEOUT_RESET : csr_wdata;
            CSR_ATTEMPT_LIMIT:
               cfg_in.attempt_limit = (csr_wdata[7:0] == '0) ? ATTEMPT_LIMIT_RESET
                                                             : csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   swc_button #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_button (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pressed   (in_ff.button_level),
      .now       (now),
      .hold_time (cfg_ff.hold_time),
      .fire      (fire)
   );

   swc_fsm #(
      .TIME_WIDTH       (TIME_WIDTH),
      .GENERATION_WIDTH (GENERATION_WIDTH)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .now           (now),
      .fire          (fire),
      .radio_event   (in_ff.radio_event),
      .close_request (in_ff.close_request),
      .cfg           (cfg_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         last_time_ff           <= '0;
         cfg_ff.hold_time       <= HOLD_TIME_RESET;
         cfg_ff.window_duration <= WINDOW_DURATION_RESET;
         cfg_ff.start_timeout   <= START_TIMEOUT_RESET;
         cfg_ff.attempt_limit   <= ATTEMPT_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
         if (step) begin
            last_time_ff <= now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> last_time_ff >= $past(last_time_ff))
      else $error("clamped time went backward");

   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted request beat not held in input register");

   a_left_only_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_active) |-> (rsp_data.time_left == '0))
      else $error("time left reported outside active window");

   a_active_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_active == (rsp_data.mode_state == MODE_ACTIVE)))
      else $error("active flag disagrees with mode");

   a_start_stop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.start_radio && rsp_data.stop_radio))
      else $error("radio start and stop in one result");

endmodule

`default_nettype wire

@@ tb/sv/swc_status_checker.sv @@
`timescale 1ns / 1ps

module swc_status_checker import swc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          status_backlog,
   output int          status_checked
);

   localparam logic [63:0] TIME_MAX = '1;

   cfg_type     cfg;
   logic [63:0] last_seen_time;
   logic [2:0]  mode;
   logic [1:0]  fault;
   logic [7:0]  attempts;
   logic [31:0] generation_count;
   logic [63:0] start_deadline;
   logic [63:0] window_end;
   bit          press_held;
   bit          press_fired;
   logic [63:0] press_origin;

   rsp_type expected_status[$];

   function automatic logic [63:0] add_capped(input logic [63:0] base, input logic [31:0] delta);
      if ({32'd0, delta} > TIME_MAX - base) return TIME_MAX;
      return base + {32'd0, delta};
   endfunction

   task automatic launch_radio(input logic [63:0] now);
      mode = MODE_STARTING;
      if (attempts < ATTEMPT_MAX) attempts = attempts + 8'd1;
      start_deadline = add_capped(now, cfg.start_timeout);
   endtask

   task automatic predict_status(input req_type beat, output rsp_type status);
      logic [63:0] now;
      logic [63:0] left;
      bit          fire;
      bit          act_start;
      bit          act_stop;
      bit          act_drop;

      act_start = 1'b0;
      act_stop  = 1'b0;
      act_drop  = 1'b0;
      fire      = 1'b0;

      // time never runs backward
      now = beat.time_now;
      if (now < last_seen_time) now = last_seen_time;
      last_seen_time = now;

      if (!beat.button_level) begin
         press_held   = 1'b0;
         press_fired  = 1'b0;
         press_origin = '0;
      end else begin
         if (!press_held) begin
            press_held   = 1'b1;
            press_origin = now;
         end
         if (now < press_origin) begin
            press_origin = now;
         end else if (!press_fired && now - press_origin >= {32'd0, cfg.hold_time}) begin
            press_fired = 1'b1;
            fire        = 1'b1;
         end
      end

      if (fire && (mode == MODE_OFF || mode == MODE_FAULT)) begin
         fault    = FAULT_NONE;
         attempts = '0;
         launch_radio(now);
         act_start = 1'b1;
      end

      // a start launched above is checked in this same beat
      case (mode)
         MODE_STARTING: begin
            if (beat.radio_event == EV_STARTED) begin
               mode           = MODE_ACTIVE;
               start_deadline = '0;
               window_end     = add_capped(now, cfg.window_duration);
            end else if (beat.radio_event == EV_FAILED || now >= start_deadline) begin
               if (attempts < cfg.attempt_limit) begin
                  launch_radio(now);
                  act_start = 1'b1;
               end else begin
                  mode             = MODE_FAULT;
                  start_deadline   = '0;
                  fault            = FAULT_START_FAILED;
                  generation_count = generation_count + 32'd1;
                  act_drop         = 1'b1;
               end
            end
         end
         MODE_ACTIVE: begin
            if (beat.radio_event == EV_STOPPED) begin
               fault            = FAULT_UNEXP_STOP;
               attempts         = '0;
               window_end       = '0;
               generation_count = generation_count + 32'd1;
               act_drop         = 1'b1;
               launch_radio(now);
               act_start = 1'b1;
            end else if (beat.close_request || now >= window_end) begin
               mode       = MODE_STOPPING;
               window_end = '0;
               act_stop   = 1'b1;
            end
         end
         MODE_STOPPING: begin
            if (beat.radio_event == EV_STOPPED) begin
               mode             = MODE_OFF;
               attempts         = '0;
               generation_count = generation_count + 32'd1;
               act_drop         = 1'b1;
            end
         end
         default: ;
      endcase

      left = '0;
      if (mode == MODE_ACTIVE && now < window_end) begin
         left = window_end - now;
         if (left > 64'hFFFF_FFFF) left = 64'hFFFF_FFFF;
      end

      status.mode_state    = mode;
      status.is_active     = (mode == MODE_ACTIVE);
      status.time_left     = left[31:0];
      status.attempts_made = attempts;
      status.generation    = generation_count;
      status.fault_code    = fault;
      status.start_radio   = act_start;
      status.stop_radio    = act_stop;
      status.drop_sessions = act_drop;
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type predicted;
      rsp_type oldest;

      if (reset) begin
         cfg.hold_time       = HOLD_TIME_RESET;
         cfg.window_duration = WINDOW_DURATION_RESET;
         cfg.start_timeout   = START_TIMEOUT_RESET;
         cfg.attempt_limit   = ATTEMPT_LIMIT_RESET;
         last_seen_time   = '0;
         mode             = MODE_OFF;
         fault            = FAULT_NONE;
         attempts         = '0;
         generation_count = '0;
         start_deadline   = '0;
         window_end       = '0;
         press_held       = 1'b0;
         press_fired      = 1'b0;
         press_origin     = '0;
         expected_status.delete();
         mismatch_count = 0;
         status_checked = 0;
      end else begin
         // zero selects the register's default
         if (csr_write_en) begin
            case (csr_index)
               CSR_HOLD_TIME:
                  cfg.hold_time = (csr_wdata == '0) ? HOLD_TIME_RESET : csr_wdata;
               CSR_WINDOW_DURATION:
                  cfg.window_duration = (csr_wdata == '0) ? WINDOW_DURATION_RESET : csr_wdata;
               CSR_START_TIMEOUT:
                  cfg.start_timeout = (csr_wdata == '0) ? START_TIMEOUT_RESET : csr_wdata;
               CSR_ATTEMPT_LIMIT:
                  cfg.attempt_limit = (csr_wdata[7:0] == '0) ? ATTEMPT_LIMIT_RESET
                                                             : csr_wdata[7:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            predict_status(req_data, predicted);
            expected_status.push_back(predicted);
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("status beat with no request outstanding");
               mismatch_count++;
            end else begin
               oldest = expected_status.pop_front();
               check_field("mode_state", oldest.mode_state, rsp_data.mode_state);
               check_field("is_active", oldest.is_active, rsp_data.is_active);
               check_field("time_left", oldest.time_left, rsp_data.time_left);
               check_field("attempts_made", oldest.attempts_made, rsp_data.attempts_made);
               check_field("generation", oldest.generation, rsp_data.generation);
               check_field("fault_code", oldest.fault_code, rsp_data.fault_code);
               check_field("start_radio", oldest.start_radio, rsp_data.start_radio);
               check_field("stop_radio", oldest.stop_radio, rsp_data.stop_radio);
               check_field("drop_sessions", oldest.drop_sessions, rsp_data.drop_sessions);
               status_checked++;
            end
         end
      end
      status_backlog = expected_status.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import swc_pkg::*;

   localparam logic [63:0] TIME_MAX = '1;

   typedef enum int {
      END_CLOSE,
      END_EXPIRY,
      END_DROPOUT
   } session_end_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_write_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int mismatch_count;
   int status_backlog;
   int status_checked;

   logic [63:0] stim_time;
   logic [31:0] hold_ms;
   logic [31:0] window_ms;
   logic [31:0] timeout_ms;
   bit          button_held;
   int          beats_sent;
   int          settings_run;
   int          sender_gap_max;

   service_window_controller DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   swc_status_checker status_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .status_backlog (status_backlog),
      .status_checked (status_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stalls, quiet stretches, and one long hold-off
   initial begin : status_sink
      int stall;
      int results;
      bit held_off;

      rsp_ready = 1'b0;
      results   = 0;
      held_off  = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (!held_off && results == 300) begin
            stall    = 120;
            held_off = 1'b1;
         end else if ((results / 40) % 3 == 0) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 12);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results++;
      end
   end

   task automatic emit(input logic [63:0] stamp, input bit btn, input radio_event_type ev,
                       input bit close_req);
      req_type beat;
      int      gap;

      beat.time_now      = stamp;
      beat.button_level  = btn;
      beat.radio_event   = ev;
      beat.close_request = close_req;
      gap = (sender_gap_max > 0) ? $urandom_range(0, sender_gap_max) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // drain everything in flight, then let the pipeline idle
   task automatic settle();
      int spins;

      spins = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_backlog != 0 && spins < 5000) begin
         @(negedge clock);
         spins++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic advance(input logic [63:0] delta);
      if (delta > TIME_MAX - stim_time) stim_time = TIME_MAX;
      else stim_time = stim_time + delta;
   endtask

   function automatic logic [63:0] stale_time();
      if (stim_time == TIME_MAX) return {$urandom, $urandom};
      return {$urandom, $urandom} % (stim_time + 64'd1);
   endfunction

   function automatic radio_event_type random_event();
      case ($urandom_range(0, 19))
         0, 1, 2, 3:  return EV_STARTED;
         4, 5, 6:     return EV_STOPPED;
         7, 8:        return EV_FAILED;
         default:     return EV_NONE;
      endcase
   endfunction

   function automatic radio_event_type quiet_event();
      case ($urandom_range(0, 5))
         0:       return EV_FAILED;
         1:       return EV_STARTED;
         default: return EV_NONE;
      endcase
   endfunction

   // time steps land near the active thresholds
   function automatic logic [63:0] random_step();
      logic [31:0] span;

      case ($urandom_range(0, 2))
         0:       span = hold_ms;
         1:       span = timeout_ms;
         default: span = window_ms;
      endcase
      case ($urandom_range(0, 7))
         0, 1:    return 64'd0;
         2, 3:    return $urandom_range(0, span / 8 + 1);
         4:       return span - 32'd1;
         5:       return span;
         6:       return {32'd0, span} + 64'd1;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   task automatic run_noise(input int count);
      logic [63:0] stamp;

      repeat (count) begin
         if ($urandom_range(0, 6) == 0) button_held = !button_held;
         advance(random_step());
         stamp = ($urandom_range(0, 11) == 0) ? stale_time() : stim_time;
         emit(stamp, button_held, random_event(), $urandom_range(0, 9) == 0);
      end
   endtask

   // press, start (with retries), active window, shutdown
   task automatic run_session();
      logic [63:0]     press_at;
      session_end_type ending;

      if (button_held || $urandom_range(0, 1) == 0) begin
         advance($urandom_range(0, 20));
         emit(stim_time, 1'b0, random_event(), 1'b0);
      end
      button_held = 1'b1;
      advance($urandom_range(1, 10));
      press_at = stim_time;
      emit(stim_time, 1'b1, EV_NONE, 1'b0);
      if (hold_ms > 32'd1 && $urandom_range(0, 1) == 0) begin
         advance(hold_ms - 32'd1);
         emit(stim_time, 1'b1, EV_NONE, 1'b0);
      end
      stim_time = press_at;
      advance({32'd0, hold_ms} + $urandom_range(0, 2));
      emit(stim_time, 1'b1, ($urandom_range(0, 3) == 0) ? EV_STARTED : EV_NONE, 1'b0);

      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 1) == 0) begin
            advance(timeout_ms);
            emit(stim_time, 1'b1, EV_NONE, 1'b0);
         end else begin
            advance($urandom_range(0, 3));
            emit(stim_time, 1'b1, EV_FAILED, 1'b0);
         end
      end

      advance($urandom_range(0, timeout_ms - 32'd1));
      button_held = $urandom_range(0, 1);
      emit(stim_time, button_held, EV_STARTED, 1'b0);

      repeat ($urandom_range(0, 4)) begin
         advance($urandom_range(0, window_ms / 4));
         emit(stim_time, button_held, quiet_event(), 1'b0);
      end

      ending = session_end_type'($urandom_range(0, 2));
      case (ending)
         END_CLOSE: begin
            advance($urandom_range(0, 5));
            emit(stim_time, button_held, EV_NONE, 1'b1);
         end
         END_EXPIRY: begin
            advance(window_ms);
            emit(stim_time, button_held, EV_NONE, 1'b0);
         end
         default: begin
            advance($urandom_range(0, 5));
            emit(stim_time, button_held, EV_STOPPED, 1'b0);
            advance($urandom_range(0, 5));
            emit(stim_time, button_held, EV_STARTED, 1'b0);
            emit(stim_time, button_held, EV_NONE, 1'b1);
         end
      endcase

      repeat ($urandom_range(0, 2)) begin
         advance($urandom_range(0, 5));
         emit(stim_time, button_held, quiet_event(), $urandom_range(0, 1));
      end
      advance($urandom_range(0, 5));
      emit(stim_time, button_held, EV_STOPPED, 1'b0);
   endtask

   task automatic run_random(input int target);
      int first;

      first = beats_sent;
      while (beats_sent - first < target) begin
         sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
         if ($urandom_range(0, 3) == 0) run_noise($urandom_range(1, 8));
         else run_session();
      end
   endtask

   task automatic run_phase(input logic [31:0] hold_w, input logic [31:0] window_w,
                            input logic [31:0] timeout_w, input logic [31:0] limit_w,
                            input int target);
      settle();
      write_reg(CSR_HOLD_TIME, hold_w);
      write_reg(CSR_WINDOW_DURATION, window_w);
      write_reg(CSR_START_TIMEOUT, timeout_w);
      write_reg(CSR_ATTEMPT_LIMIT, limit_w);
      hold_ms    = (hold_w == '0) ? HOLD_TIME_RESET : hold_w;
      window_ms  = (window_w == '0) ? WINDOW_DURATION_RESET : window_w;
      timeout_ms = (timeout_w == '0) ? START_TIMEOUT_RESET : timeout_w;
      settings_run++;
      run_random(target);
   endtask

   initial begin : stimulus
      int failures;

      req_valid      = 1'b0;
      req_data       = '0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_HOLD_TIME;
      csr_wdata      = '0;
      stim_time      = '0;
      hold_ms        = HOLD_TIME_RESET;
      window_ms      = WINDOW_DURATION_RESET;
      timeout_ms     = START_TIMEOUT_RESET;
      button_held    = 1'b0;
      beats_sent     = 0;
      settings_run   = 1;
      sender_gap_max = 12;
      wait (reset == 1'b0);

      // directed walk at the reset settings
      emit(64'd0, 1'b1, EV_NONE, 1'b0);
      emit(64'd2999, 1'b1, EV_NONE, 1'b0);
      emit(64'd3000, 1'b1, EV_NONE, 1'b0);         // hold reached
      emit(64'd3001, 1'b1, EV_STARTED, 1'b0);
      emit(64'd4000, 1'b0, EV_FAILED, 1'b0);       // ignored while active
      emit(64'd5000, 1'b0, EV_NONE, 1'b1);         // close
      emit(64'd5001, 1'b0, EV_STARTED, 1'b1);      // ignored while stopping
      emit(64'd5002, 1'b0, EV_STOPPED, 1'b0);
      emit(64'd100, 1'b1, EV_NONE, 1'b0);          // earlier time, clamped
      emit(64'd8002, 1'b1, EV_STARTED, 1'b0);      // start and started in one beat
      emit(64'd8003, 1'b1, EV_STOPPED, 1'b0);      // unexpected stop, restart
      emit(64'd18003, 1'b1, EV_NONE, 1'b0);        // deadline passes -> fault
      emit(64'd18004, 1'b0, EV_NONE, 1'b0);
      emit(64'd18005, 1'b1, EV_NONE, 1'b0);
      emit(64'd21005, 1'b1, EV_FAILED, 1'b0);      // restart from fault, fails at once
      emit(64'd60000, 1'b1, EV_NONE, 1'b0);        // latched, no second fire
      emit(64'd60001, 1'b0, EV_STOPPED, 1'b1);
      emit(64'd60002, 1'b1, EV_NONE, 1'b0);
      emit(64'd63002, 1'b1, EV_STARTED, 1'b0);
      emit(64'd963001, 1'b1, EV_NONE, 1'b0);       // 1 ms left
      emit(64'd963002, 1'b1, EV_NONE, 1'b0);       // expiry
      emit(64'd963003, 1'b1, EV_STOPPED, 1'b0);
      stim_time   = 64'd963003;
      button_held = 1'b1;

      run_random(200);
      run_phase(32'd1, 32'd1, 32'd1, 32'd1, 200);
      run_phase('0, '0, '0, '0, 120);
      run_phase(32'd40, 32'd300, 32'd60, 32'd3, 300);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 180);
      run_phase(32'd25, 32'd200, 32'd20, 32'd255, 250);
      run_phase($urandom_range(1, 500), $urandom_range(1, 5000), $urandom_range(1, 500),
                $urandom, 120);

      // top of the time range: deadlines saturate
      stim_time = TIME_MAX - 64'd64;
      run_phase(32'd5, 32'hFFFF_FFFF, 32'd100, 32'd2, 60);

      settle();
      failures = mismatch_count + status_backlog;
      $display("Sent %0d request beats over %0d register settings, checked %0d status beats.",
               beats_sent, settings_run, status_checked);
      $display("Covered press hold, start retries and faults, window close and expiry, "
               , "unexpected stops, clamped and saturated time.");
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/swc_pkg.sv
hdl/swc_button.sv
hdl/swc_fsm.sv
hdl/service_window_controller.sv
tb/sv/swc_status_checker.sv
tb/sv/testbench.sv
